// ----- sv/fba_pkg.sv -----
// Shared types and constants for the bitmap frame allocator.
`default_nettype none

package fba_pkg;

    // Geometry of the bitmap and of the frame number field
    localparam int NUM_FRAMES_DEF = 4096;
    localparam int FRAME_W        = 12;
    localparam int MAP_WORD_W     = 32;
    localparam int BIT_IDX_W      = 5;
    localparam int FIELD_FRAMES   = 4096;
    localparam int MAX_WORDS      = FIELD_FRAMES / MAP_WORD_W;

    // Command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Result status codes
    localparam logic [2:0] STAT_ALLOCATED = 3'd0;
    localparam logic [2:0] STAT_HAD_FRAME = 3'd1;
    localparam logic [2:0] STAT_NO_FREE   = 3'd2;
    localparam logic [2:0] STAT_FREED     = 3'd3;
    localparam logic [2:0] STAT_NOTHING   = 3'd4;

    // Operation of the shared bitmap word unit
    typedef enum logic {
        WOP_SET_FIRST,
        WOP_CLEAR
    } word_op_t;

    // Result of the shared bitmap word unit
    typedef struct packed {
        logic                        full;
        logic [BIT_IDX_W-1:0]        bit_idx;
        logic [MAP_WORD_W-1:0]       new_word;
    } word_res_t;

endpackage

`default_nettype wire

// ----- sv/frame_bitmap_allocator_unit.sv -----
// Top level of the bitmap first-fit physical frame allocator.
//
// Usage: raise start with cmd, frame_in, kernel_page and writable; the word
// is taken at a clock edge where start is high and busy is low. Exactly one
// result word follows, shown for a single cycle with done high on
// frame_out, present_bit, rw_bit, user_bit and status. The receiver cannot
// hold results off, so it must take the word in that cycle.
// An allocate for an entry that already holds a frame, or a free of frame
// 0 or of a frame at or past NUM_FRAMES, answers in the cycle after the
// request. A free reads, modifies and writes one bitmap word. An allocate
// scans the bitmap one word per cycle through a RAM with registered read,
// over up to WORDS words (128 words at 4096 frames); busy stays high
// meanwhile.
// Reset: all frames read as free. Each bitmap word has a valid flag that
// reset clears, so the RAM needs no clearing pass and the block can take a
// request in the first cycle after reset.
`default_nettype none

module frame_bitmap_allocator_unit #(
    parameter int NUM_FRAMES = fba_pkg::NUM_FRAMES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          cmd,
    input  wire logic [fba_pkg::FRAME_W-1:0]   frame_in,
    input  wire logic                          kernel_page,
    input  wire logic                          writable,
    output logic                               done,
    output logic      [fba_pkg::FRAME_W-1:0]   frame_out,
    output logic                               present_bit,
    output logic                               rw_bit,
    output logic                               user_bit,
    output logic      [2:0]                    status
);

    // Bitmap geometry; frames past the 12-bit field are never reachable
    localparam int MAP_WORDS = (NUM_FRAMES + fba_pkg::MAP_WORD_W - 1) / fba_pkg::MAP_WORD_W;
    localparam int WORDS     = MAP_WORDS < fba_pkg::MAX_WORDS ? MAP_WORDS : fba_pkg::MAX_WORDS;
    localparam int LIMIT     = NUM_FRAMES < fba_pkg::FIELD_FRAMES ?
                               NUM_FRAMES : fba_pkg::FIELD_FRAMES;
    localparam int ADDR_W    = WORDS > 1 ? $clog2(WORDS) : 1;
    localparam int CNT_W     = $clog2(WORDS + 1);
    localparam int FNUM_W    = fba_pkg::FRAME_W + 1;
    localparam logic [FNUM_W-1:0] LIMIT_F = FNUM_W'(LIMIT);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FREE_RD,
        ST_FREE_WR
    } state_t;

    state_t                          state_reg, state_next;
    logic [CNT_W-1:0]                idx_reg, idx_next;
    logic                            chk_reg, chk_next;
    logic [ADDR_W-1:0]               last_addr_reg;
    logic [WORDS-1:0]                valid_reg, valid_next;
    logic [fba_pkg::FRAME_W-1:0]     frame_reg, frame_next;
    logic                            kern_reg, kern_next;
    logic                            wr_reg, wr_next;
    logic                            done_reg, done_next;
    logic [fba_pkg::FRAME_W-1:0]     fout_reg, fout_next;
    logic                            present_reg, present_next;
    logic                            rw_reg, rw_next;
    logic                            user_reg, user_next;
    logic [2:0]                      status_reg, status_next;

    logic                            ram_we;
    logic [ADDR_W-1:0]               ram_waddr;
    logic [ADDR_W-1:0]               ram_raddr;
    logic [fba_pkg::MAP_WORD_W-1:0]  ram_rdata;
    logic [fba_pkg::MAP_WORD_W-1:0]  map_word;
    fba_pkg::word_op_t               wop;
    fba_pkg::word_res_t              wres;
    logic [ADDR_W-1:0]               free_addr;
    logic [FNUM_W-1:0]               found_frame;
    logic                            accept;

    // Bitmap storage
    fba_ram #(
        .WIDTH (fba_pkg::MAP_WORD_W),
        .DEPTH (WORDS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wres.new_word),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Word never written since reset reads as all free
    assign map_word = valid_reg[last_addr_reg] ? ram_rdata : '0;

    // Shared find/set/clear unit
    fba_word_unit u_word (
        .word    (map_word),
        .op      (wop),
        .bit_sel (frame_reg[fba_pkg::BIT_IDX_W-1:0]),
        .res     (wres)
    );

    assign free_addr   = frame_reg[fba_pkg::BIT_IDX_W +: ADDR_W];
    assign found_frame = (FNUM_W'(last_addr_reg) << fba_pkg::BIT_IDX_W)
                       | FNUM_W'(wres.bit_idx);
    assign accept      = start && (state_reg == ST_IDLE);

    // Sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        chk_next     = 1'b0;
        valid_next   = valid_reg;
        frame_next   = frame_reg;
        kern_next    = kern_reg;
        wr_next      = wr_reg;
        done_next    = 1'b0;
        fout_next    = fout_reg;
        present_next = present_reg;
        rw_next      = rw_reg;
        user_next    = user_reg;
        status_next  = status_reg;
        ram_we       = 1'b0;
        ram_waddr    = last_addr_reg;
        ram_raddr    = idx_reg[ADDR_W-1:0];
        wop          = fba_pkg::WOP_SET_FIRST;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    frame_next   = frame_in;
                    kern_next    = kernel_page;
                    wr_next      = writable;
                    fout_next    = '0;
                    present_next = 1'b0;
                    rw_next      = 1'b0;
                    user_next    = 1'b0;
                    if (cmd == fba_pkg::CMD_ALLOC)
                    begin
                        if (frame_in != '0)
                        begin
                            fout_next   = frame_in;
                            status_next = fba_pkg::STAT_HAD_FRAME;
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            idx_next   = '0;
                            state_next = ST_SCAN;
                        end
                    end
                    else
                    begin
                        if (frame_in != '0 && {1'b0, frame_in} < LIMIT_F)
                        begin
                            state_next = ST_FREE_RD;
                        end
                        else
                        begin
                            status_next = fba_pkg::STAT_NOTHING;
                            done_next   = 1'b1;
                        end
                    end
                end
            end

            ST_SCAN:
            begin
                // Issue the next word read while checking the previous one
                if (idx_reg < CNT_W'(WORDS))
                begin
                    chk_next = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                end
                if (chk_reg && !wres.full)
                begin
                    if (found_frame < LIMIT_F)
                    begin
                        ram_we                    = 1'b1;
                        valid_next[last_addr_reg] = 1'b1;
                        fout_next                 = found_frame[fba_pkg::FRAME_W-1:0];
                        present_next              = 1'b1;
                        rw_next                   = wr_reg;
                        user_next                 = !kern_reg;
                        status_next               = fba_pkg::STAT_ALLOCATED;
                    end
                    else
                    begin
                        status_next = fba_pkg::STAT_NO_FREE;
                    end
                    chk_next   = 1'b0;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (idx_reg == CNT_W'(WORDS))
                begin
                    status_next = fba_pkg::STAT_NO_FREE;
                    done_next   = 1'b1;
                    state_next  = ST_IDLE;
                end
            end

            ST_FREE_RD:
            begin
                ram_raddr  = free_addr;
                state_next = ST_FREE_WR;
            end

            ST_FREE_WR:
            begin
                wop                   = fba_pkg::WOP_CLEAR;
                ram_we                = 1'b1;
                ram_waddr             = free_addr;
                valid_next[free_addr] = 1'b1;
                status_next           = fba_pkg::STAT_FREED;
                done_next             = 1'b1;
                state_next            = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            chk_reg       <= 1'b0;
            last_addr_reg <= '0;
            valid_reg     <= '0;
            frame_reg     <= '0;
            kern_reg      <= 1'b0;
            wr_reg        <= 1'b0;
            done_reg      <= 1'b0;
            fout_reg      <= '0;
            present_reg   <= 1'b0;
            rw_reg        <= 1'b0;
            user_reg      <= 1'b0;
            status_reg    <= fba_pkg::STAT_ALLOCATED;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            chk_reg       <= chk_next;
            last_addr_reg <= ram_raddr;
            valid_reg     <= valid_next;
            frame_reg     <= frame_next;
            kern_reg      <= kern_next;
            wr_reg        <= wr_next;
            done_reg      <= done_next;
            fout_reg      <= fout_next;
            present_reg   <= present_next;
            rw_reg        <= rw_next;
            user_reg      <= user_next;
            status_reg    <= status_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign frame_out   = fout_reg;
    assign present_bit = present_reg;
    assign rw_bit      = rw_reg;
    assign user_bit    = user_reg;
    assign status      = status_reg;

    // A result only follows a request or running work
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(start) || $past(busy)))
        else $error("result without request");

    // Finishing work always delivers a result
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("work ended without result");

    // Bitmap writes only from scan or free write
    a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_SCAN || state_reg == ST_FREE_WR))
        else $error("bitmap write outside allocate or free");

    // An allocated frame is in range and marked present
    a_alloc_range: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == fba_pkg::STAT_ALLOCATED)
            |-> (present_bit && {1'b0, frame_out} < LIMIT_F))
        else $error("allocated frame out of range");

endmodule

`default_nettype wire

// ----- sv/fba_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module fba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- sv/fba_word_unit.sv -----
// Shared bitmap word unit: finds the lowest free bit and sets or clears one bit.
`default_nettype none

module fba_word_unit (
    input  wire logic [fba_pkg::MAP_WORD_W-1:0] word,
    input  wire fba_pkg::word_op_t              op,
    input  wire logic [fba_pkg::BIT_IDX_W-1:0]  bit_sel,
    output fba_pkg::word_res_t                  res
);

    logic [fba_pkg::BIT_IDX_W-1:0]  first_zero;
    logic [fba_pkg::MAP_WORD_W-1:0] set_mask;
    logic [fba_pkg::MAP_WORD_W-1:0] clr_mask;

    // Priority encoder for the lowest clear bit
    always_comb
    begin
        first_zero = '0;
        for (int b = fba_pkg::MAP_WORD_W - 1; b >= 0; b--)
        begin
            if (!word[b])
            begin
                first_zero = fba_pkg::BIT_IDX_W'(b);
            end
        end
    end

    assign set_mask = fba_pkg::MAP_WORD_W'(1) << first_zero;
    assign clr_mask = fba_pkg::MAP_WORD_W'(1) << bit_sel;

    // Updated word for the selected operation
    always_comb
    begin
        res.full    = &word;
        res.bit_idx = first_zero;
        case (op)
            fba_pkg::WOP_SET_FIRST: res.new_word = word | set_mask;
            fba_pkg::WOP_CLEAR:     res.new_word = word & ~clr_mask;
            default:                res.new_word = word;
        endcase
    end

endmodule

`default_nettype wire
